FILE: hw/rtl/lrs_pkg.sv
// Shared types, codes and the key-step function of the record scrambler.
package lrs_pkg;

   // Configuration register indexes
   localparam logic CSR_MODE = 1'b0;
   localparam logic CSR_SEED = 1'b1;

   // Mode codes; any other code forwards bytes unchanged
   localparam logic [1:0] MODE_SCRAMBLE   = 2'd0;
   localparam logic [1:0] MODE_UNSCRAMBLE = 2'd1;
   localparam logic [1:0] MODE_PASS       = 2'd2;

   localparam int KEY_W = 29;

   typedef logic [KEY_W-1:0] key_type;

   typedef struct packed {
      logic        start_of_image;
      logic [7:0]  data_byte;
      logic        is_data_record;
      logic [7:0]  record_byte_count;
      logic [31:0] record_address;
   } req_type;

   typedef struct packed {
      logic [7:0] out_byte;
      logic       last_of_run;
   } rsp_type;

   // One shift-left step; new bit is XNOR of bits 28 and 26
   function automatic key_type key_next(input key_type k);
      key_next = {k[KEY_W-2:0], ~(k[28] ^ k[26])};
   endfunction

endpackage

FILE: hw/rtl/lfsr_record_scrambler_unit.sv
// Top level of the record scrambler: key register, pair holding and result queue.
//
// Usage: payload bytes of firmware-image records enter on the req_ channel, one
// per transfer, together with their record's type, byte count and address.
// Transformed bytes leave on the rsp_ channel; each input causes zero, one or
// two result transfers, and last_of_run marks the final one of an input.
// A byte at an even position of a swapping record is held and gives no result
// until its partner arrives. The csr_ port writes mode and seed; the user must write them
// only while idle, as the block does not enforce it. Results are queued with their input
// transfer and offered once older ones have left. Throughput: one input per cycle; the
// input side stalls only when the four-entry result queue has fewer than two free entries,
// so with an unstalled receiver the block runs at one byte per cycle indefinitely.
// Reset: mode returns to pass through, seed and key clear, nothing is held
// and the result queue empties. When the receiver stalls, the queue fills
// and req_stall rises once less than two entries remain free.
module lfsr_record_scrambler_unit (
   input  logic             clock,
   input  logic             reset,
   input  logic             req_valid,
   output logic             req_stall,
   input  lrs_pkg::req_type req_data,
   output logic             rsp_valid,
   input  logic             rsp_stall,
   output lrs_pkg::rsp_type rsp_data,
   input  logic             csr_write,
   input  logic             csr_index,
   input  logic [31:0]      csr_wdata
);

   localparam int QDEPTH = 4;

   logic [1:0]       mode_ff;
   lrs_pkg::key_type seed_ff;
   lrs_pkg::key_type key_ff, key_in;
   logic [7:0]       held_ff, held_in;
   logic             held_valid_ff, held_valid_in;
   logic [7:0]       pos_ff, pos_in;

   lrs_pkg::rsp_type queue_ff [QDEPTH];
   logic [1:0]       wr_ptr_ff, rd_ptr_ff;
   logic [2:0]       count_ff;

   logic             req_xfer, rsp_xfer;
   lrs_pkg::key_type key_cur, key_adv;
   logic [7:0]       pos_cur;
   logic             hv_cur;
   logic             active, swap, odd;
   logic [8:0]       pos_sum;
   logic [7:0]       res0, res1;
   logic [1:0]       res_n;

   assign req_xfer  = req_valid && !req_stall;
   assign rsp_xfer  = rsp_valid && !rsp_stall;
   assign req_stall = count_ff > 3'd2;
   assign rsp_valid = count_ff != 3'd0;
   assign rsp_data  = queue_ff[rd_ptr_ff];

   // Configuration registers
   always_ff @(posedge clock) begin
      if (reset) begin
         mode_ff <= lrs_pkg::MODE_PASS;
         seed_ff <= '0;
      end else if (csr_write) begin
         case (csr_index)
            lrs_pkg::CSR_MODE: mode_ff <= csr_wdata[1:0];
            lrs_pkg::CSR_SEED: seed_ff <= csr_wdata[lrs_pkg::KEY_W-1:0];
            default: ;
         endcase
      end
   end

   // Transform of one byte: start-of-image reload, swap decision, results
   always_comb begin
      key_cur = req_data.start_of_image ? seed_ff : key_ff;
      pos_cur = req_data.start_of_image ? 8'd0 : pos_ff;
      hv_cur  = req_data.start_of_image ? 1'b0 : held_valid_ff;
      key_adv = lrs_pkg::key_next(key_cur);
      active  = req_data.is_data_record &&
                (mode_ff == lrs_pkg::MODE_SCRAMBLE || mode_ff == lrs_pkg::MODE_UNSCRAMBLE);
      swap    = active && !req_data.record_byte_count[0] && req_data.record_byte_count > 8'd2
                && (req_data.record_address[4] || req_data.record_address[7]);
      odd     = pos_cur[0];

      res0          = '0;
      res1          = '0;
      res_n         = 2'd0;
      key_in        = key_cur;
      held_in       = held_ff;
      held_valid_in = hv_cur;

      // Broken pair: held byte goes out first, as stored
      if (hv_cur && !(swap && odd)) begin
         res0          = held_ff;
         res_n         = 2'd1;
         held_valid_in = 1'b0;
      end

      if (swap && !odd) begin
         held_in       = req_data.data_byte ^
                         ((mode_ff == lrs_pkg::MODE_SCRAMBLE) ? key_cur[7:0] : key_adv[7:0]);
         key_in        = key_adv;
         held_valid_in = 1'b1;
      end else if (swap && hv_cur) begin
         // Pair completes: odd byte, then the held byte
         res0          = req_data.data_byte ^
                         ((mode_ff == lrs_pkg::MODE_SCRAMBLE) ? key_cur[7:0] : key_cur[8:1]);
         res1          = held_ff;
         res_n         = 2'd2;
         key_in        = key_adv;
         held_valid_in = 1'b0;
      end else if (active) begin
         if (res_n == 2'd0) res0 = req_data.data_byte ^ key_cur[7:0];
         else               res1 = req_data.data_byte ^ key_cur[7:0];
         res_n  = res_n + 2'd1;
         key_in = key_adv;
      end else begin
         if (res_n == 2'd0) res0 = req_data.data_byte;
         else               res1 = req_data.data_byte;
         res_n = res_n + 2'd1;
      end

      // Byte position wraps at the record's byte count
      pos_sum = {1'b0, pos_cur} + 9'd1;
      pos_in  = (pos_sum >= {1'b0, req_data.record_byte_count}) ? 8'd0 : pos_sum[7:0];
   end

   // Scrambler state
   always_ff @(posedge clock) begin
      if (reset) begin
         key_ff        <= '0;
         held_ff       <= '0;
         held_valid_ff <= 1'b0;
         pos_ff        <= '0;
      end else if (req_xfer) begin
         key_ff        <= key_in;
         held_ff       <= held_in;
         held_valid_ff <= held_valid_in;
         pos_ff        <= pos_in;
      end
   end

   // Result queue entries
   always_ff @(posedge clock) begin
      if (req_xfer) begin
         if (res_n != 2'd0) begin
            queue_ff[wr_ptr_ff] <= '{out_byte: res0, last_of_run: (res_n == 2'd1)};
         end
         if (res_n == 2'd2) begin
            queue_ff[wr_ptr_ff + 2'd1] <= '{out_byte: res1, last_of_run: 1'b1};
         end
      end
   end

   // Result queue pointers and fill count
   always_ff @(posedge clock) begin
      if (reset) begin
         wr_ptr_ff <= '0;
         rd_ptr_ff <= '0;
         count_ff  <= '0;
      end else begin
         if (req_xfer) wr_ptr_ff <= wr_ptr_ff + res_n;
         if (rsp_xfer) rd_ptr_ff <= rd_ptr_ff + 2'd1;
         count_ff <= count_ff + (req_xfer ? {1'b0, res_n} : 3'd0) - {2'b0, rsp_xfer};
      end
   end

`ifndef ASSERT_OFF
   a_queue_bound: assert property (@(posedge clock) disable iff (reset)
      count_ff <= 3'(QDEPTH))
      else $error("result queue overfilled");

   a_silent_holds: assert property (@(posedge clock) disable iff (reset)
      req_xfer && res_n == 2'd0 |=> held_valid_ff)
      else $error("input without result left no held byte");

   a_pass_keeps_key: assert property (@(posedge clock) disable iff (reset)
      req_xfer && !req_data.start_of_image &&
      !(mode_ff == lrs_pkg::MODE_SCRAMBLE || mode_ff == lrs_pkg::MODE_UNSCRAMBLE)
      |=> $stable(key_ff))
      else $error("key advanced in pass mode");
`endif

endmodule

FILE: tb/lrs_byte_checker.sv
// Checker for the record scrambler: predicts output bytes and compares each result transfer.
module lrs_byte_checker (
   input  logic             clock,
   input  logic             reset,
   input  logic             req_valid,
   input  logic             req_stall,
   input  lrs_pkg::req_type req_data,
   input  logic             rsp_valid,
   input  logic             rsp_stall,
   input  lrs_pkg::rsp_type rsp_data,
   input  logic             csr_write,
   input  logic             csr_index,
   input  logic [31:0]      csr_wdata,
   output int               fail_count,
   output int               results_due
);
   timeunit 1ns;
   timeprecision 1ps;

   // Shadow copy of the block's configuration and state
   logic [1:0]       mode_q;
   logic [31:0]      seed_q;
   lrs_pkg::key_type key;
   logic [7:0]       held;
   logic             held_valid;
   logic [7:0]       position;

   lrs_pkg::rsp_type bytes_due[$];
   lrs_pkg::rsp_type want;
   int               mismatches = 0;

   // One shift step: left shift, new bit is XNOR of bits 28 and 26
   function automatic lrs_pkg::key_type step_key(input lrs_pkg::key_type k);
      logic fresh;
      fresh = ~(k[28] ^ k[26]);
      return (k << 1) | lrs_pkg::key_type'(fresh);
   endfunction

   // Work out the output bytes caused by one input transfer
   task automatic scramble_byte(input lrs_pkg::req_type r);
      logic [7:0]       produced[$];
      logic             active;
      logic             swap;
      logic             odd;
      lrs_pkg::key_type nk;
      if (r.start_of_image) begin
         key        = seed_q[lrs_pkg::KEY_W-1:0];
         position   = '0;
         held_valid = 1'b0;
      end
      active = r.is_data_record &&
               (mode_q == lrs_pkg::MODE_SCRAMBLE || mode_q == lrs_pkg::MODE_UNSCRAMBLE);
      swap = active && !r.record_byte_count[0] && r.record_byte_count > 8'd2
             && (r.record_address[4] || r.record_address[7]);
      odd = position[0];

      // broken pair: flush the held byte as stored
      if (held_valid && !(swap && odd)) begin
         produced.push_back(held);
         held_valid = 1'b0;
      end

      if (swap && !odd) begin
         nk = step_key(key);
         held = r.data_byte ^ ((mode_q == lrs_pkg::MODE_SCRAMBLE) ? key[7:0] : nk[7:0]);
         key = nk;
         held_valid = 1'b1;
      end else if (swap && held_valid) begin
         // unscramble uses the key of the previous step for the odd byte
         produced.push_back(r.data_byte ^
                            ((mode_q == lrs_pkg::MODE_SCRAMBLE) ? key[7:0] : key[8:1]));
         key = step_key(key);
         produced.push_back(held);
         held_valid = 1'b0;
      end else if (active) begin
         produced.push_back(r.data_byte ^ key[7:0]);
         key = step_key(key);
      end else begin
         produced.push_back(r.data_byte);
      end

      for (int i = 0; i < produced.size(); i++)
         bytes_due.push_back(lrs_pkg::rsp_type'{produced[i], i == produced.size() - 1});

      if ({1'b0, position} + 9'd1 >= {1'b0, r.record_byte_count})
         position = '0;
      else
         position = position + 8'd1;
   endtask

   always @(posedge clock) begin
      if (reset) begin
         mode_q     = lrs_pkg::MODE_PASS;
         seed_q     = '0;
         key        = '0;
         held       = '0;
         held_valid = 1'b0;
         position   = '0;
         bytes_due.delete();
      end else begin
         if (csr_write) begin
            if (csr_index == lrs_pkg::CSR_MODE)
               mode_q = csr_wdata[1:0];
            else
               seed_q = csr_wdata;
         end

         if (req_valid && !req_stall)
            scramble_byte(req_data);

         // compare against the oldest expected byte
         if (rsp_valid && !rsp_stall) begin
            if (bytes_due.size() == 0) begin
               $error("unexpected result transfer: out_byte %h last_of_run %b",
                      rsp_data.out_byte, rsp_data.last_of_run);
               mismatches++;
            end else begin
               want = bytes_due.pop_front();
               if (rsp_data.out_byte !== want.out_byte) begin
                  $error("out_byte: expected %h, actual %h", want.out_byte, rsp_data.out_byte);
                  mismatches++;
               end
               if (rsp_data.last_of_run !== want.last_of_run) begin
                  $error("last_of_run: expected %b, actual %b",
                         want.last_of_run, rsp_data.last_of_run);
                  mismatches++;
               end
            end
         end
      end
      results_due <= bytes_due.size();
      fail_count  <= mismatches;
   end

endmodule

FILE: tb/lfsr_record_scrambler_unit_tb.sv
// Stimulus, receiver stalls and verdict for the record scrambler.
module lfsr_record_scrambler_unit_tb;
   timeunit 1ns;
   timeprecision 1ps;

   localparam logic [1:0] MODE_RESERVED = 2'd3;   // undefined code, acts as pass
   localparam int RANDOM_ITEMS = 1100;
   localparam int PHASE_ITEMS  = 150;
   localparam int CYCLE_LIMIT  = 300000;

   logic             clock = 1'b0;
   logic             reset = 1'b1;
   logic             req_valid = 1'b0;
   logic             req_stall;
   lrs_pkg::req_type req_data = '0;
   logic             rsp_valid;
   logic             rsp_stall = 1'b0;
   lrs_pkg::rsp_type rsp_data;
   logic             csr_write = 1'b0;
   logic             csr_index = lrs_pkg::CSR_MODE;
   logic [31:0]      csr_wdata = '0;

   int fail_count;
   int results_due;
   int cycle_count = 0;
   int burst_left = 0;
   int stall_span = 0;
   int stall_style = 0;

   lfsr_record_scrambler_unit dut (
      .clock     (clock),
      .reset     (reset),
      .req_valid (req_valid),
      .req_stall (req_stall),
      .req_data  (req_data),
      .rsp_valid (rsp_valid),
      .rsp_stall (rsp_stall),
      .rsp_data  (rsp_data),
      .csr_write (csr_write),
      .csr_index (csr_index),
      .csr_wdata (csr_wdata)
   );

   lrs_byte_checker byte_check (
      .clock       (clock),
      .reset       (reset),
      .req_valid   (req_valid),
      .req_stall   (req_stall),
      .req_data    (req_data),
      .rsp_valid   (rsp_valid),
      .rsp_stall   (rsp_stall),
      .rsp_data    (rsp_data),
      .csr_write   (csr_write),
      .csr_index   (csr_index),
      .csr_wdata   (csr_wdata),
      .fail_count  (fail_count),
      .results_due (results_due)
   );

   always #5 clock = ~clock;

   // Run limit
   always @(posedge clock) begin
      cycle_count <= cycle_count + 1;
      if (cycle_count >= CYCLE_LIMIT) begin
         $display("Some tests failed");
         $finish;
      end
   end

   // Receiver stall: a new style and span are drawn each time the span runs out
   always @(posedge clock) begin
      if (stall_span == 0) begin
         stall_span  <= $urandom_range(16, 200);
         stall_style <= $urandom_range(0, 3);
      end else begin
         stall_span <= stall_span - 1;
      end
      case (stall_style)
         0: rsp_stall <= 1'b0;
         1: rsp_stall <= ($urandom_range(0, 3) == 0);
         2: rsp_stall <= ($urandom_range(0, 3) != 0);
         default: rsp_stall <= cycle_count[3];
      endcase
   end

   // One byte transfer; bursts of random length separated by random gaps
   task automatic put(input logic sof, input logic [7:0] value, input logic is_data,
                      input logic [7:0] count, input logic [31:0] addr);
      int gap;
      if (burst_left == 0) begin
         burst_left = ($urandom_range(0, 9) == 0) ? $urandom_range(100, 300)
                                                  : $urandom_range(1, 24);
         gap = $urandom_range(0, 6);
         if (gap > 0) begin
            req_valid <= 1'b0;
            repeat (gap) @(posedge clock);
         end
      end
      req_valid <= 1'b1;
      req_data  <= lrs_pkg::req_type'{sof, value, is_data, count, addr};
      @(posedge clock);
      while (req_stall) @(posedge clock);
      burst_left--;
   endtask

   // Bytes of one record with random content; start flag only on the first
   task automatic send_record(input logic sof, input logic is_data, input logic [7:0] count,
                              input logic [31:0] addr, input int nbytes);
      for (int i = 0; i < nbytes; i++)
         put(sof && i == 0, 8'($urandom), is_data, count, addr);
   endtask

   // Drain, let the block settle, then write both registers
   task automatic configure(input logic [1:0] mode, input logic [31:0] seed);
      req_valid <= 1'b0;
      do @(posedge clock); while (results_due != 0);
      repeat (4) @(posedge clock);
      csr_write <= 1'b1;
      csr_index <= lrs_pkg::CSR_MODE;
      csr_wdata <= {30'd0, mode};
      @(posedge clock);
      csr_index <= lrs_pkg::CSR_SEED;
      csr_wdata <= seed;
      @(posedge clock);
      csr_write <= 1'b0;
   endtask

   initial begin
      int          random_items;
      int          phase_items;
      int          phase;
      int          nbytes;
      int          pick;
      logic [1:0]  mode;
      logic [31:0] seed;
      logic [7:0]  count;
      logic [31:0] addr;
      logic        sof;
      logic        fresh_phase;

      repeat (4) @(posedge clock);
      reset <= 1'b0;

      // Directed: swap gating, broken pairs, restart while holding, zero count
      configure(lrs_pkg::MODE_SCRAMBLE, 32'hFFFF_FFFF);
      put(1'b1, 8'h00, 1'b1, 8'd4, 32'h0000_0010);
      put(1'b0, 8'hFF, 1'b1, 8'd4, 32'h0000_0010);
      put(1'b0, 8'h5A, 1'b1, 8'd4, 32'h0000_0010);
      put(1'b0, 8'hA5, 1'b1, 8'd4, 32'h0000_0010);
      send_record(1'b0, 1'b1, 8'd4, 32'h0000_0080, 4);
      send_record(1'b0, 1'b1, 8'd4, 32'h0000_006F, 4);
      send_record(1'b0, 1'b1, 8'd3, 32'h0000_0090, 3);
      send_record(1'b0, 1'b0, 8'd4, 32'h0000_0090, 4);
      // pair cut short by a change of record header
      send_record(1'b0, 1'b1, 8'd6, 32'hFFFF_FFFF, 3);
      send_record(1'b0, 1'b1, 8'd255, 32'h0000_0000, 2);
      // start of image drops a held byte
      put(1'b1, 8'h33, 1'b1, 8'd4, 32'h0000_0010);
      put(1'b1, 8'hCC, 1'b1, 8'd4, 32'h0000_0010);
      put(1'b0, 8'hFF, 1'b1, 8'd4, 32'h0000_0010);
      // zero count behaves as one
      put(1'b1, 8'h77, 1'b1, 8'd0, 32'h0000_0010);

      // Random phases, each under its own mode and seed
      random_items = 0;
      phase = 0;
      while (random_items < RANDOM_ITEMS) begin
         case (phase)
            0: configure(lrs_pkg::MODE_UNSCRAMBLE, 32'h0000_0000);
            1: configure(lrs_pkg::MODE_PASS, $urandom);
            2: configure(MODE_RESERVED, $urandom);
            default: begin
               pick = $urandom_range(0, 9);
               mode = (pick < 4) ? lrs_pkg::MODE_SCRAMBLE :
                      (pick < 8) ? lrs_pkg::MODE_UNSCRAMBLE :
                      (pick == 8) ? lrs_pkg::MODE_PASS : MODE_RESERVED;
               pick = $urandom_range(0, 5);
               seed = (pick == 0) ? 32'h0000_0000 :
                      (pick == 1) ? 32'hFFFF_FFFF : $urandom;
               configure(mode, seed);
            end
         endcase
         phase_items = 0;
         fresh_phase = 1'b1;
         while (phase_items < PHASE_ITEMS && random_items < RANDOM_ITEMS) begin
            if ($urandom_range(0, 9) == 0) begin
               // noise: a lone byte with an arbitrary header
               send_record($urandom_range(0, 7) == 0, 1'($urandom_range(0, 1)),
                           8'($urandom_range(1, 255)), $urandom, 1);
               nbytes = 1;
            end else begin
               sof = fresh_phase || ($urandom_range(0, 15) == 0);
               pick = $urandom_range(0, 19);
               if (pick == 0)
                  count = 8'($urandom_range(1, 255));
               else if (pick < 14)
                  count = 8'(2 * $urandom_range(2, 8));
               else
                  count = 8'($urandom_range(1, 16));
               addr = $urandom;
               if ($urandom_range(0, 9) < 7) begin
                  if ($urandom_range(0, 1))
                     addr[4] = 1'b1;
                  else
                     addr[7] = 1'b1;
               end
               nbytes = ($urandom_range(0, 7) == 0) ? $urandom_range(1, count) : count;
               send_record(sof, $urandom_range(0, 7) != 0, count, addr, nbytes);
            end
            fresh_phase = 1'b0;
            phase_items += nbytes;
            random_items += nbytes;
         end
         phase++;
      end

      // Drain and verdict
      req_valid <= 1'b0;
      do @(posedge clock); while (results_due != 0);
      repeat (8) @(posedge clock);
      if (fail_count == 0)
         $display("All tests passed");
      else
         $display("Some tests failed");
      $finish;
   end

endmodule
